FILE: src/phfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phfe_pkg
// Shared types and constants for the packet header field extractor.
// ----------------------------------------------------------------------------
package phfe_pkg;

   localparam int MAX_RECS = 6;

   // Field identifiers
   localparam logic [4:0] FID_PORT     = 5'd0;
   localparam logic [4:0] FID_ETH_DST  = 5'd1;
   localparam logic [4:0] FID_ETH_SRC  = 5'd2;
   localparam logic [4:0] FID_ETH_TYPE = 5'd3;
   localparam logic [4:0] FID_VLAN_TCI = 5'd4;
   localparam logic [4:0] FID_IP_PROTO = 5'd5;
   localparam logic [4:0] FID_IP_SRC   = 5'd6;
   localparam logic [4:0] FID_IP_DST   = 5'd7;
   localparam logic [4:0] FID_ARP_OP   = 5'd8;
   localparam logic [4:0] FID_ARP_SHA  = 5'd9;
   localparam logic [4:0] FID_ARP_THA  = 5'd10;
   localparam logic [4:0] FID_ARP_SPA  = 5'd11;
   localparam logic [4:0] FID_ARP_TPA  = 5'd12;
   localparam logic [4:0] FID_TCP_SRC  = 5'd13;
   localparam logic [4:0] FID_TCP_DST  = 5'd14;
   localparam logic [4:0] FID_UDP_SRC  = 5'd15;
   localparam logic [4:0] FID_UDP_DST  = 5'd16;
   localparam logic [4:0] FID_DHCP_OP  = 5'd17;
   localparam logic [4:0] FID_DHCP_XID = 5'd18;
   localparam logic [4:0] FID_DHCP_CI  = 5'd19;
   localparam logic [4:0] FID_DHCP_YI  = 5'd20;
   localparam logic [4:0] FID_DHCP_CH  = 5'd21;
   localparam logic [4:0] FID_OPTION   = 5'd22;
   localparam logic [4:0] FID_END      = 5'd23;

   // Protocol constants
   localparam logic [15:0] ETH_VLAN  = 16'h8100;
   localparam logic [15:0] ETH_IPV4  = 16'h0800;
   localparam logic [15:0] ETH_ARP   = 16'h0806;
   localparam logic [7:0]  PROTO_TCP = 8'h06;
   localparam logic [7:0]  PROTO_UDP = 8'h11;
   localparam logic [15:0] PORT_DHCP_CLIENT = 16'd68;
   localparam logic [15:0] PORT_DHCP_SERVER = 16'd67;
   localparam logic [7:0]  OPT_PAD = 8'h00;
   localparam logic [7:0]  OPT_END = 8'hFF;
   localparam logic [47:0] ARP_ETH_IPV4 = 48'h000108000604;

   typedef enum logic [2:0] {
      L_ETH, L_IPV4, L_ARP, L_TCP, L_UDP, L_DHCP, L_DOPT, L_IDLE
   } layer_type;

   typedef enum logic [1:0] {
      PH_CODE, PH_LEN, PH_SKIP, PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] ingress_port;
   } req_type;

   typedef struct packed {
      logic [4:0]  field_id;
      logic [47:0] field_value;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  field_id;
      logic [47:0] field_value;
   } rec_type;

   // All records caused by one item
   typedef struct packed {
      rec_type [MAX_RECS-1:0] recs;
      logic [2:0]             count;
   } bundle_type;

   function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
      case (idx)
         2'd0: cookie_byte = 8'h63;
         2'd1: cookie_byte = 8'h82;
         2'd2: cookie_byte = 8'h53;
         default: cookie_byte = 8'h63;
      endcase
   endfunction

   function automatic bundle_type add_rec(input bundle_type b, input logic [4:0] id,
                                          input logic [47:0] val);
      bundle_type r;
      r = b;
      if (b.count < 3'(MAX_RECS)) begin
         r.recs[b.count[2:0]].field_id    = id;
         r.recs[b.count[2:0]].field_value = val;
         r.count = b.count + 3'd1;
      end
      return r;
   endfunction

endpackage

FILE: src/phfe_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phfe_parser
// Front end: tracks byte position and header layer, builds the record
// bundle caused by each accepted byte.
// ----------------------------------------------------------------------------
module phfe_parser
   import phfe_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 65535
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  req_type    item,
   output bundle_type bundle
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] lstart_ff, lstart_in;
   layer_type   layer_ff, layer_in;
   logic [47:0] cap0_ff, cap0_in, cap1_ff, cap1_in, cap2_ff, cap2_in;
   logic [47:0] cap3_ff, cap3_in, cap4_ff, cap4_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [7:0]  proto_ff, proto_in;
   logic        arp_ok_ff, arp_ok_in;
   logic [2:0]  cookie_ff, cookie_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  ocode_ff, ocode_in;
   logic [7:0]  oskip_ff, oskip_in;
   logic        tag_ff, tag_in;

   // Next state and record bundle
   always_comb begin
      logic [15:0] rel;
      logic [47:0] sh;
      logic [7:0]  b;
      logic [15:0] typ;
      logic [15:0] ihl_end;
      bundle_type  bd;
      layer_type   l4;
      b  = item.data_byte;
      bd = '0;
      pos_in = pos_ff; lstart_in = lstart_ff; layer_in = layer_ff;
      cap0_in = cap0_ff; cap1_in = cap1_ff; cap2_in = cap2_ff;
      cap3_in = cap3_ff; cap4_in = cap4_ff;
      ihl_in = ihl_ff; proto_in = proto_ff; arp_ok_in = arp_ok_ff;
      cookie_in = cookie_ff; phase_in = phase_ff; ocode_in = ocode_ff;
      oskip_in = oskip_ff; tag_in = tag_ff;
      rel = pos_ff - lstart_ff;
      sh  = {cap0_ff[39:0], b};
      typ = sh[15:0];
      ihl_end = {10'd0, ihl_ff, 2'b00} - 16'd1;
      l4 = (proto_ff == PROTO_TCP) ? L_TCP : ((proto_ff == PROTO_UDP) ? L_UDP : L_IDLE);

      if (pos_ff < 16'(MAX_PACKET_BYTES)) begin
         if (pos_ff == 16'd0)
            bd = add_rec(bd, FID_PORT, {16'd0, item.ingress_port});
         cap0_in = sh;
         case (layer_ff)
            L_ETH: begin
               if (rel == 16'd5) cap1_in = sh;
               else if (rel == 16'd11) cap2_in = sh;
               else if ((rel == 16'd13 && typ != ETH_VLAN) || rel == 16'd17) begin
                  bd = add_rec(bd, FID_ETH_DST, cap1_ff);
                  bd = add_rec(bd, FID_ETH_SRC, cap2_ff);
                  bd = add_rec(bd, FID_ETH_TYPE, {32'd0, typ});
                  if (tag_ff) bd = add_rec(bd, FID_VLAN_TCI, cap3_ff);
                  layer_in  = (typ == ETH_IPV4) ? L_IPV4 :
                              ((typ == ETH_ARP) ? L_ARP : L_IDLE);
                  lstart_in = pos_ff + 16'd1;
               end else if (rel == 16'd13) tag_in = 1'b1;
               else if (rel == 16'd15) cap3_in = {32'd0, sh[15:0]};
            end
            L_IPV4: begin
               if (rel == 16'd0) ihl_in = b[3:0];
               else if (rel == 16'd9) proto_in = b;
               else if (rel == 16'd15) cap1_in = {16'd0, sh[31:0]};
               else if (rel == 16'd19) begin
                  bd = add_rec(bd, FID_IP_PROTO, {40'd0, proto_ff});
                  bd = add_rec(bd, FID_IP_SRC, cap1_ff);
                  bd = add_rec(bd, FID_IP_DST, {16'd0, sh[31:0]});
                  if (ihl_ff < 4'd5) begin
                     layer_in = L_IDLE; lstart_in = pos_ff + 16'd1;
                  end else if (ihl_ff == 4'd5) begin
                     layer_in = l4; lstart_in = pos_ff + 16'd1;
                  end
               end else if (rel > 16'd19 && rel == ihl_end) begin
                  layer_in = l4; lstart_in = pos_ff + 16'd1;
               end
            end
            L_ARP: begin
               if (rel == 16'd5) arp_ok_in = (sh == ARP_ETH_IPV4);
               else if (rel == 16'd7) cap1_in = {32'd0, sh[15:0]};
               else if (rel == 16'd13) cap2_in = sh;
               else if (rel == 16'd17) cap3_in = {16'd0, sh[31:0]};
               else if (rel == 16'd23) cap4_in = sh;
               else if (rel == 16'd27) begin
                  if (arp_ok_ff) begin
                     bd = add_rec(bd, FID_ARP_OP, cap1_ff);
                     bd = add_rec(bd, FID_ARP_SHA, cap2_ff);
                     bd = add_rec(bd, FID_ARP_THA, cap4_ff);
                     bd = add_rec(bd, FID_ARP_SPA, cap3_ff);
                     bd = add_rec(bd, FID_ARP_TPA, {16'd0, sh[31:0]});
                  end
                  layer_in = L_IDLE; lstart_in = pos_ff + 16'd1;
               end
            end
            L_TCP: begin
               if (rel == 16'd3) cap1_in = {16'd0, sh[31:0]};
               else if (rel == 16'd19) begin
                  bd = add_rec(bd, FID_TCP_SRC, {32'd0, cap1_ff[31:16]});
                  bd = add_rec(bd, FID_TCP_DST, {32'd0, cap1_ff[15:0]});
                  layer_in = L_IDLE; lstart_in = pos_ff + 16'd1;
               end
            end
            L_UDP: begin
               if (rel == 16'd3) cap1_in = {16'd0, sh[31:0]};
               else if (rel == 16'd7) begin
                  bd = add_rec(bd, FID_UDP_SRC, {32'd0, cap1_ff[31:16]});
                  bd = add_rec(bd, FID_UDP_DST, {32'd0, cap1_ff[15:0]});
                  layer_in = (cap1_ff[31:16] == PORT_DHCP_CLIENT &&
                              cap1_ff[15:0] == PORT_DHCP_SERVER) ? L_DHCP : L_IDLE;
                  lstart_in = pos_ff + 16'd1;
               end
            end
            L_DHCP: begin
               if (rel == 16'd0) cap1_in = {40'd0, b};
               else if (rel == 16'd7) cap2_in = {16'd0, sh[31:0]};
               else if (rel == 16'd15) cap3_in = {16'd0, sh[31:0]};
               else if (rel == 16'd19) cap4_in = {16'd0, sh[31:0]};
               else if (rel == 16'd33) begin
                  bd = add_rec(bd, FID_DHCP_OP, cap1_ff);
                  bd = add_rec(bd, FID_DHCP_XID, cap2_ff);
                  bd = add_rec(bd, FID_DHCP_CI, cap3_ff);
                  bd = add_rec(bd, FID_DHCP_YI, cap4_ff);
                  bd = add_rec(bd, FID_DHCP_CH, sh);
                  layer_in = L_DOPT; lstart_in = pos_ff + 16'd1;
               end
            end
            L_DOPT: begin
               if (cookie_ff < 3'd4) begin
                  // magic cookie search
                  if (b == cookie_byte(cookie_ff[1:0])) cookie_in = cookie_ff + 3'd1;
                  else cookie_in = (b == 8'h63) ? 3'd1 : 3'd0;
               end else begin
                  case (phase_ff)
                     PH_CODE: begin
                        if (b == OPT_END) phase_in = PH_DONE;
                        else if (b != OPT_PAD) begin
                           ocode_in = b; phase_in = PH_LEN;
                        end
                     end
                     PH_LEN: begin
                        bd = add_rec(bd, FID_OPTION,
                                     {16'd0, ocode_ff, b, pos_ff + 16'd1});
                        if (b == 8'd0) phase_in = PH_CODE;
                        else begin
                           oskip_in = b; phase_in = PH_SKIP;
                        end
                     end
                     PH_SKIP: begin
                        oskip_in = oskip_ff - 8'd1;
                        if (oskip_ff == 8'd1) phase_in = PH_CODE;
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
         pos_in = pos_ff + 16'd1;
      end

      // end of packet: report and return to reset state
      if (item.last_byte) begin
         bd = add_rec(bd, FID_END, {15'd0, tag_in, 16'd0, pos_in});
         pos_in = '0; lstart_in = '0; layer_in = L_ETH;
         cap0_in = '0; cap1_in = '0; cap2_in = '0; cap3_in = '0; cap4_in = '0;
         ihl_in = '0; proto_in = '0; arp_ok_in = 1'b0; cookie_in = '0;
         phase_in = PH_CODE; ocode_in = '0; oskip_in = '0; tag_in = 1'b0;
      end
      bundle = bd;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; lstart_ff <= '0; layer_ff <= L_ETH;
         cap0_ff <= '0; cap1_ff <= '0; cap2_ff <= '0; cap3_ff <= '0; cap4_ff <= '0;
         ihl_ff <= '0; proto_ff <= '0; arp_ok_ff <= 1'b0; cookie_ff <= '0;
         phase_ff <= PH_CODE; ocode_ff <= '0; oskip_ff <= '0; tag_ff <= 1'b0;
      end else if (take) begin
         pos_ff <= pos_in; lstart_ff <= lstart_in; layer_ff <= layer_in;
         cap0_ff <= cap0_in; cap1_ff <= cap1_in; cap2_ff <= cap2_in;
         cap3_ff <= cap3_in; cap4_ff <= cap4_in;
         ihl_ff <= ihl_in; proto_ff <= proto_in; arp_ok_ff <= arp_ok_in;
         cookie_ff <= cookie_in; phase_ff <= phase_in; ocode_ff <= ocode_in;
         oskip_ff <= oskip_in; tag_ff <= tag_in;
      end
   end

endmodule

FILE: src/phfe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phfe_queue
// Two-entry bundle queue between parser and serializer.
// ----------------------------------------------------------------------------
module phfe_queue
   import phfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output bundle_type head
);

   bundle_type  mem_ff [2];
   logic        wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = mem_ff[rd_ff];

   // Pointer and count update
   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

FILE: src/phfe_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phfe_serializer
// Back end: sends the records of the head bundle one per item.
// ----------------------------------------------------------------------------
module phfe_serializer
   import phfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  bundle_type head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic [2:0] idx_ff, idx_in;
   logic       last;

   assign last      = (idx_ff == head.count - 3'd1);
   assign rsp_valid = head_valid;
   assign pop       = rsp_valid && rsp_ready && last;

   // Output record select
   always_comb begin
      rsp_data.field_id    = head.recs[idx_ff].field_id;
      rsp_data.field_value = head.recs[idx_ff].field_value;
      rsp_data.last_of_run = last;
   end

   always_comb begin
      idx_in = idx_ff;
      if (rsp_valid && rsp_ready) idx_in = last ? 3'd0 : idx_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else idx_ff <= idx_in;
   end

endmodule

FILE: src/packet_header_field_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_header_field_extractor
// Streaming Ethernet/VLAN/IPv4/ARP/TCP/UDP/DHCP header field extractor.
// ----------------------------------------------------------------------------
// The records of an accepted byte are registered in the bundle queue and reach
// the output once earlier bundles have left. Throughput: one byte per cycle while
// the queue has room; records leave at one per cycle while rsp_ready is high.
// The two-entry bundle queue sets how far the input runs ahead of the output.
// Reset (synchronous): parser returns to the Ethernet layer, queue empties.
module packet_header_field_extractor
   import phfe_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 65535
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   bundle_type bundle, head;
   logic       take, full, pop, head_valid;

   assign req_ready = ~full;
   assign take      = req_valid && req_ready;

   phfe_parser #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_parser (
      .clock, .reset, .take, .item(req_data), .bundle
   );

   phfe_queue u_queue (
      .clock, .reset,
      .push(take && bundle.count != 3'd0), .push_data(bundle), .full,
      .pop, .head_valid, .head
   );

   phfe_serializer u_ser (
      .clock, .reset, .head_valid, .head, .pop,
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule

FILE: src/phfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phfe_checker
// Port-level checks for the packet header field extractor.
// ----------------------------------------------------------------------------
module phfe_checker
   import phfe_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_id_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.field_id <= FID_END)
      else $error("field_id out of range");

   // end record always closes its run
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.field_id == FID_END) |-> rsp_data.last_of_run)
      else $error("end record not last of run");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled item changed");

   // a waiting input item stays put
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_data)))
      else $error("waiting input item changed");

endmodule

bind packet_header_field_extractor phfe_checker u_phfe_checker (
   .clock, .reset, .req_valid, .req_ready, .req_data,
   .rsp_valid, .rsp_ready, .rsp_data
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet header field extractor regression
// Sends packets byte by byte into the extractor and compares every field
// record with a behavioral parser kept in the bench. A short table of hand
// picked packets comes first, then random well-formed and broken packets.
// ----------------------------------------------------------------------------
module testbench;
   import phfe_pkg::*;

   localparam int MAX_BYTES   = 65535;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 430;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   packet_header_field_extractor #(.MAX_PACKET_BYTES(MAX_BYTES)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Parser state mirror
   logic [15:0] pos, lstart;
   layer_type   layer;
   logic [47:0] cap [6];
   logic [7:0]  ihl, proto;
   logic        arp_ok, tag_flag;
   logic [2:0]  cookie_cnt;
   phase_type   phase;
   logic [7:0]  opt_code, opt_skip;

   rsp_type     pending_recs[$];
   rsp_type     step_recs[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          items_sent = 0;

   // Packet under construction
   logic [7:0]  pkt[$];

   function automatic void parser_reset();
      pos = 0; lstart = 0; layer = L_ETH;
      foreach (cap[i]) cap[i] = '0;
      ihl = 0; proto = 0; arp_ok = 0; tag_flag = 0;
      cookie_cnt = 0; phase = PH_CODE; opt_code = 0; opt_skip = 0;
   endfunction

   function automatic void emit(logic [4:0] id, logic [47:0] v);
      rsp_type r;
      if (step_recs.size() < MAX_RECS) begin
         r.field_id = id; r.field_value = v; r.last_of_run = 1'b0;
         step_recs.push_back(r);
      end
   endfunction

   function automatic void goto_layer(layer_type l);
      layer = l; lstart = pos + 16'd1;
   endfunction

   function automatic void eth_complete(logic [15:0] et);
      emit(FID_ETH_DST, cap[1]);
      emit(FID_ETH_SRC, cap[2]);
      emit(FID_ETH_TYPE, {32'd0, et});
      if (tag_flag) emit(FID_VLAN_TCI, cap[3]);
      goto_layer(et == ETH_IPV4 ? L_IPV4 : (et == ETH_ARP ? L_ARP : L_IDLE));
   endfunction

   function automatic void goto_l4();
      goto_layer(proto == PROTO_TCP ? L_TCP : (proto == PROTO_UDP ? L_UDP : L_IDLE));
   endfunction

   // Compute the records one byte causes and queue them for checking
   function automatic void predict_byte(req_type it);
      logic [47:0] sh;
      logic [15:0] rel;
      logic [7:0]  b;
      b = it.data_byte;
      step_recs.delete();
      if (pos < 16'(MAX_BYTES)) begin
         rel = pos - lstart;
         if (pos == 0) emit(FID_PORT, {16'd0, it.ingress_port});
         sh = {cap[0][39:0], b};
         cap[0] = sh;
         case (layer)
            L_ETH: begin
               if (rel == 5) cap[1] = sh;
               else if (rel == 11) cap[2] = sh;
               else if (rel == 13) begin
                  if (sh[15:0] == ETH_VLAN) tag_flag = 1;
                  else eth_complete(sh[15:0]);
               end else if (rel == 15) cap[3] = {32'd0, sh[15:0]};
               else if (rel == 17) eth_complete(sh[15:0]);
            end
            L_IPV4: begin
               if (rel == 0) ihl = {4'd0, b[3:0]};
               else if (rel == 9) proto = b;
               else if (rel == 15) cap[1] = {16'd0, sh[31:0]};
               else if (rel == 19) begin
                  emit(FID_IP_PROTO, {40'd0, proto});
                  emit(FID_IP_SRC, cap[1]);
                  emit(FID_IP_DST, {16'd0, sh[31:0]});
                  if (ihl < 5) goto_layer(L_IDLE);
                  else if (ihl == 5) goto_l4();
               end else if (rel > 19 && rel == 16'(ihl * 4 - 1)) goto_l4();
            end
            L_ARP: begin
               if (rel == 5) arp_ok = (sh == ARP_ETH_IPV4);
               else if (rel == 7) cap[1] = {32'd0, sh[15:0]};
               else if (rel == 13) cap[2] = sh;
               else if (rel == 17) cap[3] = {16'd0, sh[31:0]};
               else if (rel == 23) cap[4] = sh;
               else if (rel == 27) begin
                  if (arp_ok) begin
                     emit(FID_ARP_OP, cap[1]);
                     emit(FID_ARP_SHA, cap[2]);
                     emit(FID_ARP_THA, cap[4]);
                     emit(FID_ARP_SPA, cap[3]);
                     emit(FID_ARP_TPA, {16'd0, sh[31:0]});
                  end
                  goto_layer(L_IDLE);
               end
            end
            L_TCP: begin
               if (rel == 3) cap[1] = {16'd0, sh[31:0]};
               else if (rel == 19) begin
                  emit(FID_TCP_SRC, {32'd0, cap[1][31:16]});
                  emit(FID_TCP_DST, {32'd0, cap[1][15:0]});
                  goto_layer(L_IDLE);
               end
            end
            L_UDP: begin
               if (rel == 3) cap[1] = {16'd0, sh[31:0]};
               else if (rel == 7) begin
                  emit(FID_UDP_SRC, {32'd0, cap[1][31:16]});
                  emit(FID_UDP_DST, {32'd0, cap[1][15:0]});
                  goto_layer((cap[1][31:16] == PORT_DHCP_CLIENT &&
                              cap[1][15:0] == PORT_DHCP_SERVER) ? L_DHCP : L_IDLE);
               end
            end
            L_DHCP: begin
               if (rel == 0) cap[1] = {40'd0, b};
               else if (rel == 7) cap[2] = {16'd0, sh[31:0]};
               else if (rel == 15) cap[3] = {16'd0, sh[31:0]};
               else if (rel == 19) cap[4] = {16'd0, sh[31:0]};
               else if (rel == 33) begin
                  emit(FID_DHCP_OP, cap[1]);
                  emit(FID_DHCP_XID, cap[2]);
                  emit(FID_DHCP_CI, cap[3]);
                  emit(FID_DHCP_YI, cap[4]);
                  emit(FID_DHCP_CH, sh);
                  goto_layer(L_DOPT);
               end
            end
            L_DOPT: begin
               // cookie hunt, then option walk
               if (cookie_cnt < 4) begin
                  if (b == cookie_byte(cookie_cnt[1:0])) cookie_cnt++;
                  else cookie_cnt = (b == 8'h63) ? 3'd1 : 3'd0;
               end else begin
                  case (phase)
                     PH_CODE: begin
                        if (b == OPT_END) phase = PH_DONE;
                        else if (b != OPT_PAD) begin
                           opt_code = b; phase = PH_LEN;
                        end
                     end
                     PH_LEN: begin
                        emit(FID_OPTION, {16'd0, opt_code, b, pos + 16'd1});
                        if (b == 0) phase = PH_CODE;
                        else begin
                           opt_skip = b; phase = PH_SKIP;
                        end
                     end
                     PH_SKIP: begin
                        opt_skip--;
                        if (opt_skip == 0) phase = PH_CODE;
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
         pos++;
      end
      if (it.last_byte) begin
         emit(FID_END, {15'd0, tag_flag, 16'd0, pos});
         parser_reset();
      end
      if (step_recs.size() > 0) step_recs[step_recs.size()-1].last_of_run = 1'b1;
      foreach (step_recs[i]) pending_recs.push_back(step_recs[i]);
   endfunction

   // Check records as they are accepted
   always @(posedge clock) begin
      rsp_type exp_rec;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_recs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected record id=%0d value=%h", rsp_data.field_id,
                        rsp_data.field_value);
         end else begin
            exp_rec = pending_recs.pop_front();
            if (rsp_data !== exp_rec) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("record mismatch: exp id=%0d val=%h last=%b got id=%0d val=%h last=%b",
                           exp_rec.field_id, exp_rec.field_value, exp_rec.last_of_run,
                           rsp_data.field_id, rsp_data.field_value, rsp_data.last_of_run);
            end
         end
      end
   end

   // Receiver stall pattern: phases of full speed and phases of random stalls
   always @(negedge clock) begin
      int sel;
      sel = (cycles / 300) % 3;
      if (reset) rsp_ready <= 1'b0;
      else if (sel == 0) rsp_ready <= 1'b1;
      else if (sel == 1) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= ($urandom_range(0, 2) == 0);
   end

   // Timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("packet_header_field_extractor regression: fail");
         $finish;
      end
   end

   int burst_left = 0;

   // Send one byte; bursts of random length, random gaps between them
   task automatic send_byte(logic [7:0] b, logic lst, logic [31:0] port);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_data.data_byte <= b;
      req_data.last_byte <= lst;
      req_data.ingress_port <= port;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_byte('{data_byte: b, last_byte: lst, ingress_port: port});
      items_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_packet(logic [31:0] port);
      foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, port);
   endtask

   task automatic add_bytes(logic [47:0] v, int n);
      for (int i = n - 1; i >= 0; i--) pkt.push_back(v[i*8 +: 8]);
   endtask

   task automatic add_eth(bit vlan, logic [15:0] et);
      add_bytes(48'({$urandom, $urandom}), 6);
      add_bytes(48'({$urandom, $urandom}), 6);
      if (vlan) begin
         add_bytes(48'(ETH_VLAN), 2);
         add_bytes(48'($urandom), 2);
      end
      add_bytes(48'(et), 2);
   endtask

   task automatic add_ipv4(logic [7:0] pr, logic [3:0] hl);
      pkt.push_back({4'h4, hl});
      for (int i = 1; i < 9; i++) pkt.push_back(8'($urandom));
      pkt.push_back(pr);
      add_bytes(48'($urandom), 2);
      add_bytes(48'($urandom), 4);
      add_bytes(48'($urandom), 4);
      for (int i = 5; i < hl; i++) add_bytes(48'($urandom), 4);
   endtask

   task automatic add_udp(logic [15:0] s, logic [15:0] d);
      add_bytes(48'(s), 2); add_bytes(48'(d), 2); add_bytes(48'($urandom), 4);
   endtask

   // DHCP fixed part, cookie (sometimes preceded by noise) and options
   task automatic add_dhcp(int nopts);
      int len;
      for (int i = 0; i < 34; i++) pkt.push_back(8'($urandom));
      if ($urandom_range(0, 3) == 0) begin
         pkt.push_back(8'h63); pkt.push_back(8'h63);
      end
      add_bytes(48'h63825363, 4);
      for (int k = 0; k < nopts; k++) begin
         case ($urandom_range(0, 5))
            0: pkt.push_back(OPT_PAD);
            1: begin pkt.push_back(8'($urandom_range(1, 254))); pkt.push_back(8'd0); end
            default: begin
               pkt.push_back(8'($urandom_range(1, 254)));
               len = $urandom_range(1, 6);
               pkt.push_back(8'(len));
               repeat (len) pkt.push_back(8'($urandom));
            end
         endcase
      end
      if ($urandom_range(0, 1)) pkt.push_back(OPT_END);
      if ($urandom_range(0, 1)) add_bytes(48'({$urandom, $urandom}), $urandom_range(1, 6));
   endtask

   task automatic build_random();
      bit v;
      int kind;
      v = $urandom_range(0, 3) == 0;
      pkt.delete();
      kind = $urandom_range(0, 9);
      case (kind)
         0: begin
            add_eth(v, ETH_ARP);
            if ($urandom_range(0, 3) != 0) add_bytes(ARP_ETH_IPV4, 6);
            else add_bytes(48'({$urandom, $urandom}), 6);
            for (int i = 0; i < 22; i++) pkt.push_back(8'($urandom));
         end
         1: begin add_eth(v, ETH_IPV4); add_ipv4(PROTO_TCP, 4'd5);
                  for (int i = 0; i < 20; i++) pkt.push_back(8'($urandom)); end
         2, 3, 4: begin
            add_eth(v, ETH_IPV4); add_ipv4(PROTO_UDP, 4'($urandom_range(5, 7)));
            add_udp(PORT_DHCP_CLIENT, PORT_DHCP_SERVER); add_dhcp($urandom_range(0, 6));
         end
         5: begin add_eth(v, ETH_IPV4); add_ipv4(PROTO_UDP, 4'd5);
                  add_udp(16'($urandom), 16'($urandom)); end
         6: begin add_eth(v, 16'($urandom)); add_bytes(48'($urandom), 4); end
         7: begin add_eth(v, ETH_IPV4); add_ipv4(8'($urandom), 4'($urandom)); end
         default: repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
      endcase
      // random truncation or tail
      if ($urandom_range(0, 4) == 0) begin
         int keep;
         keep = $urandom_range(1, pkt.size());
         while (pkt.size() > keep) void'(pkt.pop_back());
      end else if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
      end
   endtask

   typedef struct {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] ingress_port;
      logic [4:0]  check_id;
      logic [47:0] check_value;
      bit          has_check;
   } row_type;

   // Directed rows: short packets whose records are known by hand; the third and fourth rows form one two-byte packet
   row_type directed_rows[] = '{
      '{8'h00, 1'b1, 32'h0000_0000, FID_END, 48'd1, 1'b1},
      '{8'hFF, 1'b1, 32'hFFFF_FFFF, FID_END, 48'd1, 1'b1},
      '{8'hA5, 1'b0, 32'h5A5A_5A5A, FID_PORT, 48'h5A5A5A5A, 1'b1},
      '{8'h5A, 1'b1, 32'h0000_0001, FID_END, 48'd2, 1'b1}
   };

   initial begin
      rsp_type seen;
      parser_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].data_byte, directed_rows[i].last_byte,
                   directed_rows[i].ingress_port);
         if (directed_rows[i].has_check) begin
            seen = pending_recs[pending_recs.size() - 1];
            if (seen.field_id != directed_rows[i].check_id ||
                seen.field_value != directed_rows[i].check_value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("table row %0d: expected id=%0d val=%h", i,
                           directed_rows[i].check_id, directed_rows[i].check_value);
            end
         end
      end
      // Directed packets: tagged IPv4/UDP/DHCP, ARP, TCP, IPv6, double tag,
      // short IHL, ICMP, IP options
      pkt.delete(); add_eth(1, ETH_IPV4); add_ipv4(PROTO_UDP, 4'd6);
      add_udp(PORT_DHCP_CLIENT, PORT_DHCP_SERVER); add_dhcp(5);
      pkt.push_back(8'd53); pkt.push_back(8'd40); send_packet(32'hFFFF_FFFF);
      pkt.delete(); add_eth(0, ETH_ARP); add_bytes(ARP_ETH_IPV4, 6);
      repeat (22) pkt.push_back(8'hFF); send_packet(32'd0);
      pkt.delete(); add_eth(0, ETH_IPV4); add_ipv4(PROTO_TCP, 4'd5);
      repeat (20) pkt.push_back(8'h00); send_packet(32'd1);
      pkt.delete(); add_eth(0, 16'h86DD); repeat (40) pkt.push_back(8'($urandom));
      send_packet(32'd2);
      pkt.delete(); add_eth(1, ETH_VLAN); repeat (20) pkt.push_back(8'($urandom));
      send_packet(32'd3);
      pkt.delete(); add_eth(0, ETH_IPV4); add_ipv4(8'h01, 4'd15); send_packet(32'd4);
      pkt.delete(); add_eth(0, ETH_IPV4); add_ipv4(PROTO_UDP, 4'd3);
      repeat (8) pkt.push_back(8'($urandom)); send_packet(32'd5);

      // Pause until everything has drained
      req_valid <= 1'b0;
      while (pending_recs.size() != 0) @(negedge clock);

      // Random packets up to the item budget
      while (items_sent < ITEM_TARGET) begin
         build_random();
         send_packet($urandom);
      end

      req_valid <= 1'b0;
      while (pending_recs.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0 && pending_recs.size() == 0)
         $display("packet_header_field_extractor regression: pass");
      else
         $display("packet_header_field_extractor regression: fail");
      $finish;
   end
endmodule

FILE: filelist.f
src/phfe_pkg.sv
src/phfe_parser.sv
src/phfe_queue.sv
src/phfe_serializer.sv
src/packet_header_field_extractor.sv
src/phfe_checker.sv
bench/testbench.sv
